@@ sv/skyb_pkg.sv @@
// ----------------------------------------------------------------------------
// skyb_pkg
// Types and constants shared by the skyline block allocator modules.
// ----------------------------------------------------------------------------
package skyb_pkg;

   // fixed field widths
   localparam int PIX_W      = 13;   // request width / height in pixels
   localparam int POS_W      = 12;   // result position in pixels
   localparam int FILL_W     = 7;    // column fill height in chunks
   localparam int CNT_W      = 7;    // columns_in_use / rows_in_use registers
   localparam int SHIFT_W    = 3;    // chunk_shift register
   localparam int CHUNK_W    = 10;   // size in chunks, and scratch count width
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;

   localparam logic [SHIFT_W-1:0] SHIFT_MIN = 3'd4;
   localparam logic [SHIFT_W-1:0] SHIFT_MAX = 3'd6;

   // request kinds
   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_CLEAR = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CHUNK_SHIFT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLUMNS     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS        = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_FWD,
      ST_BWD,
      ST_DECIDE,
      ST_WRITE,
      ST_RESP
   } ctrl_state_type;

   typedef struct packed {
      logic load;        // latch request and register snapshot
      logic fwd_init;
      logic fwd_run;     // forward pass: block prefix maxima
      logic bwd_init;
      logic bwd_run;     // backward pass: suffix maxima and window pick
      logic decide;
      logic wr_run;      // raise the covered columns
      logic clear_fill;
      logic rsp_load;
   } skyb_cmd_type;

   typedef struct packed {
      logic is_clear;
      logic reject;      // no start column or zero size
      logic pass_done;
      logic success;
      logic wr_last;
      logic rsp_busy;
   } skyb_status_type;

   function automatic logic [FILL_W-1:0] fill_max(input logic [FILL_W-1:0] a,
                                                  input logic [FILL_W-1:0] b);
      fill_max = (a > b) ? a : b;
   endfunction

endpackage

@@ sv/skyb_ctrl.sv @@
// ----------------------------------------------------------------------------
// skyb_ctrl
// Sequencer for the allocator: check, two scan passes, decision, write-back
// and result hand-off.
// ----------------------------------------------------------------------------
module skyb_ctrl import skyb_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  skyb_status_type status,
   output skyb_cmd_type    cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.is_clear) begin
               cmd.clear_fill = 1'b1;
               state_in       = ST_RESP;
            end else if (status.reject) begin
               state_in = ST_RESP;
            end else begin
               cmd.fwd_init = 1'b1;
               state_in     = ST_FWD;
            end
         end
         ST_FWD: begin
            if (status.pass_done) begin
               cmd.bwd_init = 1'b1;
               state_in     = ST_BWD;
            end else begin
               cmd.fwd_run = 1'b1;
            end
         end
         ST_BWD: begin
            if (status.pass_done) begin
               state_in = ST_DECIDE;
            end else begin
               cmd.bwd_run = 1'b1;
            end
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = status.success ? ST_WRITE : ST_RESP;
         end
         ST_WRITE: begin
            cmd.wr_run = 1'b1;
            if (status.wr_last) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!status.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ sv/skyb_datapath.sv @@
// ----------------------------------------------------------------------------
// skyb_datapath
// Register file, column height memory with valid bits, block maxima scratch
// memory, scan arithmetic and the result register.
// ----------------------------------------------------------------------------
module skyb_datapath import skyb_pkg::*; #(
   parameter int MAX_COLUMNS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_type,
   input  logic [PIX_W-1:0]      req_rect_width,
   input  logic [PIX_W-1:0]      req_rect_height,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic                  rsp_ready,
   input  skyb_cmd_type          cmd,
   output skyb_status_type       status,
   output logic                  rsp_valid,
   output logic                  rsp_ok,
   output logic [POS_W-1:0]      rsp_pos_x,
   output logic [POS_W-1:0]      rsp_pos_y
);

   localparam int IDX_W  = $clog2(MAX_COLUMNS);
   localparam int COLS_W = $clog2(MAX_COLUMNS + 1);
   localparam int CW     = CHUNK_W;
   localparam int SUM_W  = PIX_W + 1;
   localparam int XS_W   = 16;

   // configuration
   logic [SHIFT_W-1:0] csr_shift_ff, csr_shift_in;
   logic [CNT_W-1:0]   csr_cols_ff, csr_cols_in;
   logic [CNT_W-1:0]   csr_rows_ff, csr_rows_in;

   // request snapshot
   logic               clear_ff, clear_in;
   logic [SHIFT_W-1:0] sh_ff, sh_in;
   logic [CW-1:0]      wc_ff, wc_in;
   logic [CW-1:0]      hc_ff, hc_in;
   logic [COLS_W-1:0]  cols_ff, cols_in;
   logic [CNT_W-1:0]   rows_ff, rows_in;

   // scan control
   logic [COLS_W-1:0]  idx_ff, idx_in;
   logic               iss_on_ff, iss_on_in;
   logic               p_valid_ff, p_valid_in;
   logic [COLS_W-1:0]  p_idx_ff, p_idx_in;
   logic [COLS_W-1:0]  c_ff, c_in;
   logic [FILL_W-1:0]  run_max_ff, run_max_in;
   logic [FILL_W-1:0]  min_ff, min_in;
   logic [COLS_W-1:0]  bx_ff, bx_in;
   logic               found_ff, found_in;
   logic               succ_ff, succ_in;
   logic [COLS_W-1:0]  cnt_ff, cnt_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_ok_ff, rsp_ok_in;
   logic [POS_W-1:0]   rsp_x_ff, rsp_x_in;
   logic [POS_W-1:0]   rsp_y_ff, rsp_y_in;

   // memories
   logic [FILL_W-1:0]      fill_mem [MAX_COLUMNS];
   logic [FILL_W-1:0]      pm_mem   [MAX_COLUMNS];
   logic [MAX_COLUMNS-1:0] fill_vld_ff, fill_vld_in;
   logic [FILL_W-1:0]      rd_data_ff;
   logic                   rd_vld_ff;
   logic [FILL_W-1:0]      pm_rd_ff;

   logic               fill_we, pm_we;
   logic [IDX_W-1:0]   rd_addr, pm_rd_addr, pm_wr_addr, wr_addr;
   logic [CW-1:0]      pm_sum, wr_sum, wc_m1, h_sum;
   logic [FILL_W-1:0]  f, pref, suf, wmax;
   logic [COLS_W-1:0]  last_idx, c_cur, c_back;
   logic               c_at_end, blk_end, win_ok, success;
   logic [SHIFT_W-1:0] sh_eff;
   logic [SUM_W-1:0]   w_sum, h_pix_sum, round_add;
   logic [CW-1:0]      wc_calc, hc_calc;
   logic [COLS_W-1:0]  cols_eff;
   logic [XS_W-1:0]    x_sh, y_sh;

   // request decode
   always_comb begin
      if (csr_shift_ff < SHIFT_MIN) begin
         sh_eff = SHIFT_MIN;
      end else if (csr_shift_ff > SHIFT_MAX) begin
         sh_eff = SHIFT_MAX;
      end else begin
         sh_eff = csr_shift_ff;
      end
   end

   assign round_add = (SUM_W'(1) << sh_eff) - SUM_W'(1);
   assign w_sum     = SUM_W'(req_rect_width) + round_add;
   assign h_pix_sum = SUM_W'(req_rect_height) + round_add;
   assign wc_calc   = CW'(w_sum >> sh_eff);
   assign hc_calc   = CW'(h_pix_sum >> sh_eff);
   assign cols_eff  = (CW'(csr_cols_ff) > CW'(MAX_COLUMNS)) ? COLS_W'(MAX_COLUMNS)
                                                           : COLS_W'(csr_cols_ff);

   // scan arithmetic
   assign f        = rd_vld_ff ? rd_data_ff : '0;
   assign last_idx = cols_ff - COLS_W'(2);
   assign wc_m1    = wc_ff - CW'(1);
   assign c_at_end = (CW'(c_ff) == wc_m1);
   assign c_cur    = ((p_idx_ff == '0) || c_at_end) ? '0 : c_ff + COLS_W'(1);
   assign pref     = (c_cur == '0) ? f : fill_max(run_max_ff, f);
   assign blk_end  = (p_idx_ff == last_idx) || c_at_end;
   assign suf      = blk_end ? f : fill_max(run_max_ff, f);
   assign c_back   = (c_ff == '0) ? COLS_W'(wc_m1) : c_ff - COLS_W'(1);
   assign win_ok   = (CW'(p_idx_ff) + wc_ff) < CW'(cols_ff);
   assign wmax     = fill_max(suf, pm_rd_ff);

   assign pm_sum     = CW'(idx_ff) + wc_m1;
   assign rd_addr    = idx_ff[IDX_W-1:0];
   assign pm_rd_addr = pm_sum[IDX_W-1:0];
   assign pm_wr_addr = p_idx_ff[IDX_W-1:0];
   assign wr_sum     = CW'(bx_ff) + CW'(cnt_ff);
   assign wr_addr    = wr_sum[IDX_W-1:0];

   assign h_sum   = CW'(min_ff) + hc_ff;
   assign success = found_ff && (h_sum <= CW'(rows_ff));

   assign x_sh = XS_W'(bx_ff) << sh_ff;
   assign y_sh = XS_W'(min_ff) << sh_ff;

   always_comb begin
      csr_shift_in = csr_shift_ff;
      csr_cols_in  = csr_cols_ff;
      csr_rows_in  = csr_rows_ff;
      clear_in     = clear_ff;
      sh_in        = sh_ff;
      wc_in        = wc_ff;
      hc_in        = hc_ff;
      cols_in      = cols_ff;
      rows_in      = rows_ff;
      idx_in       = idx_ff;
      iss_on_in    = iss_on_ff;
      p_valid_in   = p_valid_ff;
      p_idx_in     = p_idx_ff;
      c_in         = c_ff;
      run_max_in   = run_max_ff;
      min_in       = min_ff;
      bx_in        = bx_ff;
      found_in     = found_ff;
      succ_in      = succ_ff;
      cnt_in       = cnt_ff;
      fill_vld_in  = fill_vld_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      fill_we      = 1'b0;
      pm_we        = 1'b0;

      if (csr_valid) begin
         case (csr_index)
            CSR_CHUNK_SHIFT: csr_shift_in = csr_data[SHIFT_W-1:0];
            CSR_COLUMNS:     csr_cols_in  = csr_data[CNT_W-1:0];
            CSR_ROWS:        csr_rows_in  = csr_data[CNT_W-1:0];
            default: ;
         endcase
      end

      if (cmd.load) begin
         clear_in = (req_type == REQ_CLEAR);
         sh_in    = sh_eff;
         wc_in    = wc_calc;
         hc_in    = hc_calc;
         cols_in  = cols_eff;
         rows_in  = csr_rows_ff;
         succ_in  = 1'b0;
      end

      if (cmd.fwd_init) begin
         idx_in     = '0;
         iss_on_in  = 1'b1;
         p_valid_in = 1'b0;
      end

      if (cmd.bwd_init) begin
         idx_in     = last_idx;
         iss_on_in  = 1'b1;
         p_valid_in = 1'b0;
         found_in   = 1'b0;
      end

      // issue side: one memory read per cycle, the registered data arrives in the next cycle
      if (cmd.fwd_run || cmd.bwd_run) begin
         p_valid_in = iss_on_ff;
         p_idx_in   = idx_ff;
         if (iss_on_ff) begin
            if (cmd.fwd_run) begin
               if (idx_ff == last_idx) begin
                  iss_on_in = 1'b0;
               end else begin
                  idx_in = idx_ff + COLS_W'(1);
               end
            end else begin
               if (idx_ff == '0) begin
                  iss_on_in = 1'b0;
               end else begin
                  idx_in = idx_ff - COLS_W'(1);
               end
            end
         end
      end

      // forward: running maximum from each block start
      if (cmd.fwd_run && p_valid_ff) begin
         c_in       = c_cur;
         run_max_in = pref;
         pm_we      = 1'b1;
      end

      // backward: running maximum to each block end, joined with the prefix
      // maximum at the window's right edge; ties move left
      if (cmd.bwd_run && p_valid_ff) begin
         c_in       = c_back;
         run_max_in = suf;
         if (win_ok && (!found_ff || (wmax <= min_ff))) begin
            min_in   = wmax;
            bx_in    = p_idx_ff;
            found_in = 1'b1;
         end
      end

      if (cmd.decide) begin
         succ_in = success;
         cnt_in  = '0;
      end

      if (cmd.wr_run) begin
         fill_we              = 1'b1;
         fill_vld_in[wr_addr] = 1'b1;
         cnt_in               = cnt_ff + COLS_W'(1);
      end

      if (cmd.clear_fill) begin
         fill_vld_in = '0;
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_ok_in    = clear_ff | succ_ff;
         rsp_x_in     = succ_ff ? x_sh[POS_W-1:0] : '0;
         rsp_y_in     = succ_ff ? y_sh[POS_W-1:0] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_shift_ff <= SHIFT_MAX;
         csr_cols_ff  <= CNT_W'(64);
         csr_rows_ff  <= CNT_W'(64);
         iss_on_ff    <= 1'b0;
         p_valid_ff   <= 1'b0;
         found_ff     <= 1'b0;
         succ_ff      <= 1'b0;
         clear_ff     <= 1'b0;
         fill_vld_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         csr_shift_ff <= csr_shift_in;
         csr_cols_ff  <= csr_cols_in;
         csr_rows_ff  <= csr_rows_in;
         iss_on_ff    <= iss_on_in;
         p_valid_ff   <= p_valid_in;
         found_ff     <= found_in;
         succ_ff      <= succ_in;
         clear_ff     <= clear_in;
         fill_vld_ff  <= fill_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sh_ff      <= sh_in;
      wc_ff      <= wc_in;
      hc_ff      <= hc_in;
      cols_ff    <= cols_in;
      rows_ff    <= rows_in;
      idx_ff     <= idx_in;
      p_idx_ff   <= p_idx_in;
      c_ff       <= c_in;
      run_max_ff <= run_max_in;
      min_ff     <= min_in;
      bx_ff      <= bx_in;
      cnt_ff     <= cnt_in;
      rsp_ok_ff  <= rsp_ok_in;
      rsp_x_ff   <= rsp_x_in;
      rsp_y_ff   <= rsp_y_in;
   end

   always_ff @(posedge clock) begin
      if (fill_we) begin
         fill_mem[wr_addr] <= h_sum[FILL_W-1:0];
      end
      rd_data_ff <= fill_mem[rd_addr];
      rd_vld_ff  <= fill_vld_ff[rd_addr];
      if (pm_we) begin
         pm_mem[pm_wr_addr] <= pref;
      end
      pm_rd_ff <= pm_mem[pm_rd_addr];
   end

   assign status.is_clear  = clear_ff;
   assign status.reject    = (wc_ff == '0) || (hc_ff == '0) || (wc_ff >= CW'(cols_ff));
   assign status.pass_done = !iss_on_ff && !p_valid_ff;
   assign status.success   = success;
   assign status.wr_last   = (CW'(cnt_ff) == wc_m1);
   assign status.rsp_busy  = rsp_valid_ff && !rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_ok    = rsp_ok_ff;
   assign rsp_pos_x = rsp_x_ff;
   assign rsp_pos_y = rsp_y_ff;

endmodule

@@ sv/skyline_block_allocator.sv @@
// ----------------------------------------------------------------------------
// skyline_block_allocator
// Skyline rectangle allocator for a 2D atlas of square chunks.
// ----------------------------------------------------------------------------
// One request is in work at a time; a finished result sits in an output
// register while the next request is taken. A clear or a request with no
// start column goes from the check straight to the result. An allocation
// sweeps the single read port of the column height memory once forward
// (block prefix maxima) and once backward (suffix maxima and window
// choice), and a placement then writes W columns, W being the width in
// chunks, one a cycle. Column heights are tracked by per-column valid bits,
// so reset and clear need no sweep. Configuration writes are always taken
// and apply to the next request.
// ----------------------------------------------------------------------------
module skyline_block_allocator import skyb_pkg::*; #(
   parameter int MAX_COLUMNS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_type,
   input  logic [PIX_W-1:0]      req_rect_width,
   input  logic [PIX_W-1:0]      req_rect_height,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_ok,
   output logic [POS_W-1:0]      rsp_pos_x,
   output logic [POS_W-1:0]      rsp_pos_y,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   skyb_cmd_type    cmd;
   skyb_status_type status;

   assign csr_ready = 1'b1;

   skyb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   skyb_datapath #(
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_type        (req_type),
      .req_rect_width  (req_rect_width),
      .req_rect_height (req_rect_height),
      .csr_valid       (csr_valid && csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .rsp_ready       (rsp_ready),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_ok          (rsp_ok),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y)
   );

`ifndef ASSERT_OFF
   // a transfer starts work, so no second request is taken right behind it
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while another is in work");

   // a new result appears exactly as the sequencer goes back to idle
   a_result_at_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready)
      else $error("result raised while a request is still in work");

   // a refused allocation reports no position
   a_fail_no_pos: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ok) |-> (rsp_pos_x == '0 && rsp_pos_y == '0))
      else $error("failed allocation carries a position");
`endif

endmodule
